// ===== rtl/ple_pkg.sv =====
// Shared constants for the positional list engine.
package ple_pkg;
    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int ST_W      = 2;
    localparam int LEN_W     = 5;

    localparam logic [OP_W-1:0] OP_PREPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_VAL = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_AT  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    localparam logic [VAL_W-1:0] FAIL_VALUE = '1;
endpackage

// ===== rtl/ple_if.sv =====
// Handshake channel interfaces for operations and results.
interface ple_in_if;
    logic                             valid;
    logic                             ready;
    logic [ple_pkg::OP_W-1:0]         opcode;
    logic signed [ple_pkg::VAL_W-1:0] value;
    logic [ple_pkg::POS_W-1:0]        position;
    modport source (output valid, opcode, value, position, input ready);
    modport sink   (input valid, opcode, value, position, output ready);
endinterface

interface ple_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ple_pkg::VAL_W-1:0] result_value;
    logic [ple_pkg::ST_W-1:0]         status;
    logic [ple_pkg::LEN_W-1:0]        length;
    modport source (output valid, result_value, status, length, input ready);
    modport sink   (input valid, result_value, status, length, output ready);
endinterface

// ===== rtl/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to DEPTH signed 32-bit values held in one
// RAM by position. Each operation beat gives exactly one result beat (value, status, new
// length). A new operation is taken only once the previous result beat has been taken.
// Inserts and removals move each later entry one place through the single RAM port pair,
// and remove-by-value compares each entry in turn up to the match.
module positional_list_engine #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ple_in_if.sink     i_in,
    ple_out_if.source  o_out
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_WR   = 4'd2;
    localparam logic [3:0] S_FIND_RD = 4'd3;
    localparam logic [3:0] S_FIND_CK = 4'd4;
    localparam logic [3:0] S_GET_RD  = 4'd5;
    localparam logic [3:0] S_GET_CK  = 4'd6;
    localparam logic [3:0] S_DN_RD   = 4'd7;
    localparam logic [3:0] S_DN_WR   = 4'd8;

    logic [3:0]                   r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_idx, n_idx;
    logic [ple_pkg::OP_W-1:0]     r_op, n_op;
    logic [ple_pkg::VAL_W-1:0]    r_val, n_val;
    logic [XW-1:0]                r_pos, n_pos;
    logic                         r_ovalid, n_ovalid;
    logic [ple_pkg::VAL_W-1:0]    r_res, n_res;
    logic [ple_pkg::ST_W-1:0]     r_st, n_st;

    logic                         we;
    logic [AW-1:0]                waddr, raddr;
    logic [ple_pkg::VAL_W-1:0]    wdata, rdata;
    logic                         in_acc;
    logic [XW-1:0]                in_pos, cnt_x;

    ple_ram #(.WIDTH(ple_pkg::VAL_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign i_in.ready         = (r_state == S_IDLE) && !r_ovalid;
    assign in_acc             = i_in.valid && i_in.ready;
    assign o_out.valid        = r_ovalid;
    assign o_out.result_value = r_res;
    assign o_out.status       = r_st;
    assign o_out.length       = ple_pkg::LEN_W'(r_count);
    assign cnt_x              = XW'(r_count);
    assign in_pos             = XW'(i_in.position);

    // operation sequencer: checks, then read-modify-write passes over the RAM
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_op     = r_op;
        n_val    = r_val;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_res    = r_res;
        n_st     = r_st;
        we       = 1'b0;
        waddr    = r_idx[AW-1:0];
        wdata    = rdata;
        raddr    = r_idx[AW-1:0];

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in.opcode;
                    n_val = i_in.value;
                    n_res = ple_pkg::FAIL_VALUE;
                    n_idx = r_count;
                    unique case (i_in.opcode)
                        ple_pkg::OP_PREPEND, ple_pkg::OP_APPEND, ple_pkg::OP_INSERT: begin
                            if (i_in.opcode == ple_pkg::OP_PREPEND) begin
                                n_pos = '0;
                            end else if (i_in.opcode == ple_pkg::OP_APPEND) begin
                                n_pos = cnt_x;
                            end else begin
                                n_pos = in_pos;
                            end
                            if (r_count >= CW'(DEPTH)) begin
                                n_st = ple_pkg::ST_FULL;
                                n_ovalid = 1'b1;
                            end else if (i_in.opcode == ple_pkg::OP_INSERT
                                         && in_pos > cnt_x) begin
                                n_st = ple_pkg::ST_RANGE;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_UP_RD;
                            end
                        end
                        ple_pkg::OP_REM_VAL: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_st = ple_pkg::ST_MISS;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_FIND_RD;
                            end
                        end
                        ple_pkg::OP_REM_AT, ple_pkg::OP_READ: begin
                            n_pos = in_pos;
                            n_idx = CW'(i_in.position);
                            if (r_count == '0) begin
                                n_st = ple_pkg::ST_MISS;
                                n_ovalid = 1'b1;
                            end else if (in_pos >= cnt_x) begin
                                n_st = ple_pkg::ST_RANGE;
                                n_ovalid = 1'b1;
                            end else begin
                                n_state = S_GET_RD;
                            end
                        end
                        default: begin
                            n_res = '0;
                            n_st = ple_pkg::ST_OK;
                            n_ovalid = 1'b1;
                        end
                    endcase
                end
            end
            // open a gap: move entries up from the tail down to the target
            S_UP_RD: begin
                if (r_idx == CW'(r_pos)) begin
                    we = 1'b1;
                    wdata = r_val;
                    n_count = r_count + 1'b1;
                    n_res = '0;
                    n_st = ple_pkg::ST_OK;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    raddr = AW'(r_idx - 1'b1);
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                we = 1'b1;
                n_idx = r_idx - 1'b1;
                n_state = S_UP_RD;
            end
            // linear scan for the first matching value
            S_FIND_RD: begin
                n_state = S_FIND_CK;
            end
            S_FIND_CK: begin
                if (rdata == r_val) begin
                    n_res = rdata;
                    n_state = S_DN_RD;
                end else if (r_idx + 1'b1 == r_count) begin
                    n_st = ple_pkg::ST_MISS;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_GET_RD: begin
                n_state = S_GET_CK;
            end
            S_GET_CK: begin
                n_res = rdata;
                if (r_op == ple_pkg::OP_READ) begin
                    n_st = ple_pkg::ST_OK;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DN_RD;
                end
            end
            // close a gap: move later entries down one place
            S_DN_RD: begin
                if (r_idx + 1'b1 >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_st = ple_pkg::ST_OK;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    raddr = AW'(r_idx + 1'b1);
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                we = 1'b1;
                n_idx = r_idx + 1'b1;
                n_state = S_DN_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // operation and result payload
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_op  <= n_op;
        r_val <= n_val;
        r_pos <= n_pos;
        r_res <= n_res;
        r_st  <= n_st;
    end
endmodule

// ===== dv/ple_scoreboard.sv =====
// Scoreboard class: list predictor plus queue of expected result beats.
`timescale 1ns / 100ps
class ple_scoreboard;
    typedef struct packed {
        logic [31:0] res;
        logic [1:0]  st;
        logic [4:0]  len;
    } t_ple_result;

    logic [31:0] list_q[$];
    t_ple_result pending_q[$];
    int          mismatches;
    int          checked;

    // Predict the result of one accepted operation and update the list.
    function void note_op(logic [2:0] op, logic [31:0] v, logic [4:0] pos);
        t_ple_result r;
        int          p;
        bit          hit;
        r.res = '0;
        r.st  = ple_pkg::ST_OK;
        hit   = 0;
        p     = pos;
        case (op)
            ple_pkg::OP_PREPEND, ple_pkg::OP_APPEND, ple_pkg::OP_INSERT: begin
                if (op == ple_pkg::OP_PREPEND) p = 0;
                else if (op == ple_pkg::OP_APPEND) p = list_q.size();
                if (list_q.size() >= ple_pkg::DEPTH_DEF) begin
                    r.st  = ple_pkg::ST_FULL;
                    r.res = ple_pkg::FAIL_VALUE;
                end else if (p > list_q.size()) begin
                    r.st  = ple_pkg::ST_RANGE;
                    r.res = ple_pkg::FAIL_VALUE;
                end else begin
                    list_q.insert(p, v);
                end
            end
            ple_pkg::OP_REM_VAL: begin
                r.st  = ple_pkg::ST_MISS;
                r.res = ple_pkg::FAIL_VALUE;
                for (int i = 0; i < list_q.size() && !hit; i++) begin
                    if (list_q[i] == v) begin
                        hit   = 1;
                        r.res = list_q[i];
                        r.st  = ple_pkg::ST_OK;
                        list_q.delete(i);
                    end
                end
            end
            ple_pkg::OP_REM_AT, ple_pkg::OP_READ: begin
                if (list_q.size() == 0) begin
                    r.st  = ple_pkg::ST_MISS;
                    r.res = ple_pkg::FAIL_VALUE;
                end else if (p >= list_q.size()) begin
                    r.st  = ple_pkg::ST_RANGE;
                    r.res = ple_pkg::FAIL_VALUE;
                end else begin
                    r.res = list_q[p];
                    if (op == ple_pkg::OP_REM_AT) list_q.delete(p);
                end
            end
            default: ;
        endcase
        r.len = 5'(list_q.size());
        pending_q.push_back(r);
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(logic [31:0] res, logic [1:0] st, logic [4:0] len);
        t_ple_result e;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result beat val=%h st=%0d len=%0d",
                         res, st, len);
            return;
        end
        e = pending_q.pop_front();
        checked++;
        if (e.res !== res || e.st !== st || e.len !== len) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d exp val=%h st=%0d len=%0d, %s",
                         checked, e.res, e.st, e.len,
                         $sformatf("got val=%h st=%0d len=%0d", res, st, len));
        end
    endfunction
endclass

// ===== dv/positional_list_engine_test.sv =====
// Testbench top for the positional list engine.
`timescale 1ns / 100ps
module positional_list_engine_test;
    localparam int STALL_LIMIT = 20000;
    // opcodes with no operation behind them
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_stall_pct;
    int   idle_cycles = 0;
    bit   timed_out;
    int   op_tally[8];

    ple_in_if  op_ch ();
    ple_out_if res_ch ();
    ple_scoreboard list_sb;

    positional_list_engine i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch.sink),
        .o_out  (res_ch.source)
    );

    // Clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result sink with random stalls; check each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            list_sb.check_result(res_ch.result_value, res_ch.status, res_ch.length);
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("ERROR: watchdog expired");
            $display("positional_list_engine test failed");
            $finish;
        end
    end

    // Drive one operation beat, with random idle gaps before it
    task automatic send_op(logic [2:0] op, logic [31:0] v, logic [4:0] pos);
        while ($urandom_range(99) < src_idle_pct) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid    <= 1'b1;
        op_ch.opcode   <= op;
        op_ch.value    <= v;
        op_ch.position <= pos;
        @(posedge i_clk);
        while (!op_ch.ready) @(posedge i_clk);
        list_sb.note_op(op, v, pos);
        op_tally[op]++;
    endtask

    // Random operation biased toward small values and, for remove-by-value, values already in the list
    task automatic send_random();
        logic [31:0] v;
        logic [2:0]  op;
        int          sz;
        sz = list_sb.list_q.size();
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = 32'hFFFF_FFFF;
            2: v = 32'h8000_0000;
            default: v = $urandom_range(7);
        endcase
        op = 3'($urandom_range(ple_pkg::OP_READ));
        if ($urandom_range(19) == 0) op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        if (op == ple_pkg::OP_REM_VAL && sz > 0 && $urandom_range(1))
            v = list_sb.list_q[$urandom_range(sz - 1)];
        send_op(op, v, ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                 : 5'($urandom_range(sz + 1)));
    endtask

    initial begin
        int n;
        list_sb       = new();
        i_rst_n       = 1'b0;
        op_ch.valid   = 1'b0;
        op_ch.opcode  = ple_pkg::OP_PREPEND;
        op_ch.value   = '0;
        op_ch.position = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list failures, extremes, fill to full, removals
        send_op(ple_pkg::OP_READ, 0, 0);
        send_op(ple_pkg::OP_REM_AT, 0, 0);
        send_op(ple_pkg::OP_REM_VAL, 5, 0);
        send_op(ple_pkg::OP_INSERT, 32'h7FFF_FFFF, 1);
        send_op(ple_pkg::OP_INSERT, 32'h7FFF_FFFF, 0);
        send_op(ple_pkg::OP_PREPEND, 32'h8000_0000, 0);
        send_op(ple_pkg::OP_APPEND, 32'hFFFF_FFFF, 0);
        send_op(ple_pkg::OP_READ, 0, 2);
        send_op(ple_pkg::OP_READ, 0, 3);
        send_op(ple_pkg::OP_READ, 0, 31);
        send_op(OP_SPARE_LO, 1, 1);
        send_op(OP_SPARE_HI, 2, 2);
        for (int k = 0; k < 13; k++) send_op(ple_pkg::OP_APPEND, k, 0);
        send_op(ple_pkg::OP_APPEND, 99, 0);
        send_op(ple_pkg::OP_INSERT, 99, 16);
        send_op(ple_pkg::OP_READ, 0, 15);
        send_op(ple_pkg::OP_REM_AT, 0, 15);
        send_op(ple_pkg::OP_INSERT, 42, 15);
        send_op(ple_pkg::OP_REM_VAL, 32'hFFFF_FFFF, 0);
        send_op(ple_pkg::OP_REM_VAL, 1234, 0);
        send_op(ple_pkg::OP_REM_AT, 0, 0);

        // Random phases with varying idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
                3: begin src_idle_pct = 10; snk_stall_pct = 10; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; end
            endcase
            for (n = 0; n < 150; n++) send_random();
        end
        op_ch.valid <= 1'b0;

        while (list_sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d results; ops pre/app/ins/remv/remat/read/unused: %s",
                 list_sb.checked,
                 $sformatf("%0d/%0d/%0d/%0d/%0d/%0d/%0d", op_tally[0], op_tally[1],
                           op_tally[2], op_tally[3], op_tally[4], op_tally[5],
                           op_tally[6] + op_tally[7]));
        $display("Mismatches: %0d", list_sb.mismatches);
        if (list_sb.mismatches == 0)
            $display("positional_list_engine test passed");
        else
            $display("positional_list_engine test failed");
        $finish;
    end
endmodule
